[src/alarm_compare_timer_top_assert.svh]
// Assertion macros used by the alarm compare timer RTL.
`ifndef ALARM_COMPARE_TIMER_TOP_ASSERT_SVH
`define ALARM_COMPARE_TIMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACT_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/act_pkg.sv]
// Types and constants shared by the alarm compare timer modules.
`default_nettype none

package act_pkg;

    localparam int unsigned TimeWidth = 64;
    localparam int unsigned WordWidth = 32;
    localparam int unsigned StepWidth = 20;
    localparam int unsigned OfsWidth  = 12;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    localparam logic [OfsWidth-1:0] OFS_TIME_LOW   = 12'h000;
    localparam logic [OfsWidth-1:0] OFS_TIME_HIGH  = 12'h004;
    localparam logic [OfsWidth-1:0] OFS_ALARM_LOW  = 12'h008;
    localparam logic [OfsWidth-1:0] OFS_ALARM_HIGH = 12'h00c;
    localparam logic [OfsWidth-1:0] OFS_CLEAR_IRQ  = 12'h010;
    localparam logic [OfsWidth-1:0] OFS_CLEAR_ALM  = 12'h014;

    localparam logic [StepWidth-1:0] STEP_RESET = 20'd1;

    typedef struct packed {
        logic [1:0]           operation;
        logic [OfsWidth-1:0]  offset;
        logic [WordWidth-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [WordWidth-1:0] read_data;
        logic                 irq_level;
        logic                 bad_access;
    } result_t;

endpackage

`default_nettype wire

[src/act_core.sv]
// Timer state and the combinational execution logic for one bus or tick transaction.
`default_nettype none

module act_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [act_pkg::StepWidth-1:0]   cfg_data,
    input  wire logic                            fire,
    input  wire act_pkg::item_t                  item,
    output act_pkg::result_t                     result
);
    import act_pkg::*;

    logic [StepWidth-1:0] step_reg;
    logic [TimeWidth-1:0] time_count_reg, time_count_next;
    logic [TimeWidth-1:0] time_latch_reg, time_latch_next;
    logic [WordWidth-1:0] alarm_high_reg, alarm_high_next;
    logic [TimeWidth-1:0] deadline_reg, deadline_next;
    logic                 armed_reg, armed_next;
    logic                 irq_reg, irq_next;

    logic [TimeWidth-1:0] time_sum;
    logic [TimeWidth-1:0] alarm_value;
    logic [WordWidth-1:0] rdata;
    logic                 bad;

    assign time_sum    = time_count_reg + {{(TimeWidth-StepWidth){1'b0}}, step_reg};
    assign alarm_value = {alarm_high_reg, item.write_data};

    always_comb
    begin
        time_count_next = time_count_reg;
        time_latch_next = time_latch_reg;
        alarm_high_next = alarm_high_reg;
        deadline_next   = deadline_reg;
        armed_next      = armed_reg;
        irq_next        = irq_reg;
        rdata           = '0;
        bad             = 1'b0;
        case (op_t'(item.operation))
            OP_TICK:
            begin
                time_count_next = time_sum;
                if (armed_reg && ($signed(deadline_reg) <= $signed(time_sum)))
                begin
                    armed_next = 1'b0;
                    irq_next   = 1'b1;
                end
            end
            OP_READ:
            begin
                case (item.offset)
                    OFS_TIME_LOW:
                    begin
                        time_latch_next = time_count_reg;
                        rdata           = time_count_reg[WordWidth-1:0];
                    end
                    OFS_TIME_HIGH: rdata = time_latch_reg[TimeWidth-1:WordWidth];
                    default:       bad   = 1'b1;
                endcase
            end
            OP_WRITE:
            begin
                case (item.offset)
                    OFS_ALARM_LOW:
                    begin
                        // An alarm already due fires at once and leaves any armed deadline alone.
                        if ($signed(alarm_value) <= $signed(time_count_reg))
                        begin
                            irq_next = 1'b1;
                        end
                        else
                        begin
                            deadline_next = alarm_value;
                            armed_next    = 1'b1;
                        end
                    end
                    OFS_ALARM_HIGH: alarm_high_next = item.write_data;
                    OFS_CLEAR_ALM:
                    begin
                        armed_next = 1'b0;
                        irq_next   = 1'b0;
                    end
                    OFS_CLEAR_IRQ:  irq_next = 1'b0;
                    default:        bad      = 1'b1;
                endcase
            end
            default: bad = 1'b1;
        endcase
    end

    assign result.read_data  = rdata;
    assign result.irq_level  = irq_next;
    assign result.bad_access = bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_RESET;
            time_count_reg <= '0;
            time_latch_reg <= '0;
            alarm_high_reg <= '0;
            deadline_reg   <= '0;
            armed_reg      <= 1'b0;
            irq_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_data;
            end
            if (fire)
            begin
                time_count_reg <= time_count_next;
                time_latch_reg <= time_latch_next;
                alarm_high_reg <= alarm_high_next;
                deadline_reg   <= deadline_next;
                armed_reg      <= armed_next;
                irq_reg        <= irq_next;
            end
        end
    end

    `include "alarm_compare_timer_top_assert.svh"

    `ACT_ASSERT_NEXT(a_time_only_on_tick, clk, rst_n,
        !(fire && (item.operation == OP_TICK)), $stable(time_count_reg),
        "time counter moved without a tick transaction")
    `ACT_ASSERT_NEXT(a_irq_holds_when_idle, clk, rst_n, !fire, $stable(irq_reg),
        "interrupt changed without a transaction")
    `ACT_ASSERT_NEXT(a_clear_alarm, clk, rst_n,
        fire && (item.operation == OP_WRITE) && (item.offset == OFS_CLEAR_ALM),
        !armed_reg && !irq_reg, "clear alarm left the alarm armed or the interrupt high")
    `ACT_ASSERT_SAME(a_bad_reads_zero, clk, rst_n, fire && result.bad_access,
        result.read_data == '0, "rejected access returned non-zero read data")

endmodule

`default_nettype wire

[src/act_out_reg.sv]
// Result register that holds one finished transaction until the receiver takes it.
`default_nettype none

module act_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire act_pkg::result_t  d,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output act_pkg::result_t       q,
    output logic                   can_load
);
    import act_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A new result may enter when the register is empty or its contents leave this cycle.
    assign can_load = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= d;
        end
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

`default_nettype wire

[src/alarm_compare_timer_top.sv]
// Top level of the 64-bit nanosecond timer with one compare alarm.
//
// Usage: every transaction on the input channel (in_valid, in_stall, operation, offset,
// write_data) is a tick, a register read or a register write, and produces exactly one
// result transaction on the output channel (out_valid, out_stall, read_data, irq_level,
// bad_access), in order. The step per tick is written over cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while no transaction is in flight.
// Pipeline: an accepted transaction waits in the input register, is executed as it moves
// into the result register, and its result is offered from there until it is taken.
// Throughput: one transaction per cycle while out_stall is low; the 64-bit add and signed
// compare are combinational between the input register and the result register.
// Stalls: the result register holds its transaction while out_stall is high; the input
// register then still accepts one more transaction, if it is empty, before in_stall rises.
// Reset: rst_n clears the counter, latch, alarm, deadline, armed and interrupt state,
// sets the step to 1 ns and empties both registers.
`default_nettype none

module alarm_compare_timer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [act_pkg::StepWidth-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    operation,
    input  wire logic [act_pkg::OfsWidth-1:0]  offset,
    input  wire logic [act_pkg::WordWidth-1:0] write_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [act_pkg::WordWidth-1:0]      read_data,
    output logic                               irq_level,
    output logic                               bad_access
);
    import act_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    can_load;
    logic    fire;
    result_t core_result;
    result_t out_result;

    assign cfg_ready = 1'b1;

    // The held transaction executes as it moves into the result register.
    assign fire     = in_valid_reg && can_load;
    assign in_stall = in_valid_reg && !can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.operation  <= operation;
            item_reg.offset     <= offset;
            item_reg.write_data <= write_data;
        end
    end

    act_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .fire     (fire),
        .item     (item_reg),
        .result   (core_result)
    );

    act_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .d         (core_result),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .q         (out_result),
        .can_load  (can_load)
    );

    assign read_data  = out_result.read_data;
    assign irq_level  = out_result.irq_level;
    assign bad_access = out_result.bad_access;

endmodule

`default_nettype wire
